### design/utf8_decoder_with_replacement_defines.svh
// Assertion macros for the UTF-8 decoder RTL.
`ifndef UTF8_DECODER_WITH_REPLACEMENT_DEFINES_SVH
`define UTF8_DECODER_WITH_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while aresetn is low
`define UTF8D_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("utf8 decoder: same-cycle check failed");

// Next-cycle implication, sampled on aclk, off while aresetn is low
`define UTF8D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("utf8 decoder: next-cycle check failed");

`endif

### design/utf8d_pkg.sv
// Types and constants shared by the UTF-8 decoder modules.
`default_nettype none
package utf8d_pkg;

    localparam int WIN_DEPTH = 4;
    localparam int FILL_W    = 3;
    localparam int CP_W      = 21;

    localparam logic [CP_W-1:0] ERROR_CODE = 21'd63;
    localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
    localparam logic [CP_W-1:0] MIN_TWO    = 21'h000080;
    localparam logic [CP_W-1:0] MIN_THREE  = 21'h000800;
    localparam logic [CP_W-1:0] MIN_FOUR   = 21'h010000;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_LO    = 8'hE0;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_LO    = 8'hF0;
    localparam logic [7:0] LEAD4_HI    = 8'hF4;
    localparam logic [1:0] CONT_TAG    = 2'b10;

    // held bytes, entry 0 is the oldest
    typedef logic [WIN_DEPTH-1:0][7:0] window_t;

    // outcome of one decode step on the window front
    typedef struct packed {
        logic              has_result;
        logic [CP_W-1:0]   code;
        logic              bad;
        logic [FILL_W-1:0] drop;
    } step_t;

endpackage
`default_nettype wire

### design/utf8_decoder_with_replacement.sv
// UTF-8 decoder with replacement: sequencer, pending result and output register.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   input   | s_valid s_ready s_data_byte s_end_of_text      | in
//   result  | m_valid m_ready m_code_point m_replaced        | out
//           | m_last_of_run                                  |
//
// A byte is accepted in ST_IDLE; in ST_EVAL the shared decode unit then yields one
// result per step plus a closing step, results 0..4 per byte. It runs once per cycle
// on the window front unless a stalled result channel holds it; a result is held
// one step so last_of_run is known when it moves to the output register.
// Reset (synchronous, aresetn low) empties the window and clears all valids.
// A stalled result channel holds the sequencer only when a result must move out.
`default_nettype none
`include "utf8_decoder_with_replacement_defines.svh"
module utf8_decoder_with_replacement (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic        s_end_of_text,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [20:0]      m_code_point,
    output logic             m_replaced,
    output logic             m_last_of_run
);

    typedef enum logic {ST_IDLE, ST_EVAL} state_t;

    state_t                          state_reg, state_next;
    logic [utf8d_pkg::FILL_W-1:0]    fill_reg, fill_next;
    logic [utf8d_pkg::FILL_W-1:0]    n_reg, n_next;
    logic                            at_end_reg, at_end_next;
    logic                            pend_valid_reg, pend_valid_next;
    logic [utf8d_pkg::CP_W-1:0]      pend_code_reg, pend_code_next;
    logic                            pend_bad_reg, pend_bad_next;
    logic                            m_valid_reg, m_valid_next;
    logic [utf8d_pkg::CP_W-1:0]      m_code_reg, m_code_next;
    logic                            m_bad_reg, m_bad_next;
    logic                            m_last_reg, m_last_next;

    logic                            in_beat;
    logic [utf8d_pkg::FILL_W-1:0]    wr_pos;
    logic                            run_done;
    logic                            need_emit;
    logic                            out_free;
    logic                            advance;
    logic                            shift_en;
    utf8d_pkg::window_t              window;
    utf8d_pkg::step_t                step;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_beat = s_valid && s_ready;
    // a full window overwrites its last entry
    assign wr_pos  = (fill_reg >= 3'(utf8d_pkg::WIN_DEPTH)) ? 3'd3 : fill_reg;

    utf8d_window u_window (
        .aclk     (aclk),
        .wr_en    (in_beat),
        .wr_idx   (wr_pos[1:0]),
        .wr_data  (s_data_byte),
        .shift_en (shift_en),
        .shift_n  (step.drop),
        .window   (window)
    );

    utf8d_step u_step (
        .window (window),
        .fill   (fill_reg),
        .at_end (at_end_reg),
        .step   (step)
    );

    // run ends on an empty window, a waiting lead, or four results
    assign run_done  = (fill_reg == 3'd0) || (n_reg == 3'd4) || !step.has_result;
    assign need_emit = pend_valid_reg;
    assign out_free  = !m_valid_reg || m_ready;
    assign advance   = (state_reg == ST_EVAL) && (!need_emit || out_free);
    assign shift_en  = advance && !run_done;

    // sequencer next state
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        n_next          = n_reg;
        at_end_next     = at_end_reg;
        pend_valid_next = pend_valid_reg;
        pend_code_next  = pend_code_reg;
        pend_bad_next   = pend_bad_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_code_next     = m_code_reg;
        m_bad_next      = m_bad_reg;
        m_last_next     = m_last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    fill_next   = wr_pos + 3'd1;
                    n_next      = 3'd0;
                    at_end_next = s_end_of_text;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (advance) begin
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_code_next  = pend_code_reg;
                        m_bad_next   = pend_bad_reg;
                        m_last_next  = run_done;
                    end
                    if (run_done) begin
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end else begin
                        pend_valid_next = 1'b1;
                        pend_code_next  = step.code;
                        pend_bad_next   = step.bad;
                        fill_next       = fill_reg - step.drop;
                        n_next          = n_reg + 3'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            fill_reg       <= '0;
            n_reg          <= '0;
            at_end_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            n_reg          <= n_next;
            at_end_reg     <= at_end_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_code_reg <= pend_code_next;
        pend_bad_reg  <= pend_bad_next;
        m_code_reg    <= m_code_next;
        m_bad_reg     <= m_bad_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_code_point  = m_code_reg;
    assign m_replaced    = m_bad_reg;
    assign m_last_of_run = m_last_reg;

    // between bytes at most three bytes wait and nothing is pending
    `UTF8D_ASSERT_IMP(a_idle_fill, state_reg == ST_IDLE, fill_reg <= 3'd3 && !pend_valid_reg)
    // a step that produces a result consumes between one and fill bytes
    `UTF8D_ASSERT_IMP(a_drop_range, shift_en, step.drop != 3'd0 && step.drop <= fill_reg)
    // each consumed sequence bumps the run count
    `UTF8D_ASSERT_NEXT(a_run_count, shift_en, n_reg == $past(n_reg) + 3'd1)
    // a run never exceeds four results
    `UTF8D_ASSERT_IMP(a_run_limit, state_reg == ST_EVAL, n_reg <= 3'd4)

endmodule
`default_nettype wire

### design/utf8d_window.sv
// Byte window: append at the fill index, shift out consumed bytes from the front.
`default_nettype none
module utf8d_window (
    input  wire logic                      aclk,
    input  wire logic                      wr_en,
    input  wire logic [1:0]                wr_idx,
    input  wire logic [7:0]                wr_data,
    input  wire logic                      shift_en,
    input  wire logic [utf8d_pkg::FILL_W-1:0] shift_n,
    output utf8d_pkg::window_t             window
);

    utf8d_pkg::window_t win_reg;
    utf8d_pkg::window_t win_next;

    // front shift by 1..4, entries past the end keep stale data
    always_comb begin
        logic [utf8d_pkg::FILL_W:0] src;
        win_next = win_reg;
        src = '0;
        if (shift_en) begin
            for (int k = 0; k < utf8d_pkg::WIN_DEPTH; k++) begin
                src = 4'(k) + {1'b0, shift_n};
                if (src < 4'(utf8d_pkg::WIN_DEPTH)) begin
                    win_next[k] = win_reg[src[1:0]];
                end
            end
        end else if (wr_en) begin
            win_next[wr_idx] = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

    assign window = win_reg;

endmodule
`default_nettype wire

### design/utf8d_step.sv
// Shared decode unit: evaluates one sequence at the window front per cycle.
`default_nettype none
module utf8d_step (
    input  wire utf8d_pkg::window_t        window,
    input  wire logic [utf8d_pkg::FILL_W-1:0] fill,
    input  wire logic                      at_end,
    output utf8d_pkg::step_t               step
);

    logic [7:0]                    lead;
    logic [1:0]                    need;
    logic [3:1]                    cont;
    logic [utf8d_pkg::FILL_W-1:0]  seq_len;
    logic [utf8d_pkg::FILL_W-1:0]  bad_at;
    logic [utf8d_pkg::CP_W-1:0]    value;
    logic                          value_ok;

    assign lead = window[0];

    // continuation bytes needed after the lead
    always_comb begin
        if (lead >= utf8d_pkg::LEAD4_LO && lead <= utf8d_pkg::LEAD4_HI) begin
            need = 2'd3;
        end else if (lead >= utf8d_pkg::LEAD3_LO && lead <= utf8d_pkg::LEAD3_HI) begin
            need = 2'd2;
        end else if (lead >= utf8d_pkg::LEAD2_LO && lead <= utf8d_pkg::LEAD2_HI) begin
            need = 2'd1;
        end else begin
            need = 2'd0;
        end
    end

    assign seq_len = {1'b0, need} + 3'd1;

    always_comb begin
        for (int k = 1; k < utf8d_pkg::WIN_DEPTH; k++) begin
            cont[k] = (window[k][7:6] == utf8d_pkg::CONT_TAG);
        end
    end

    // first position that is not a continuation, zero if all are good
    always_comb begin
        if (!cont[1]) begin
            bad_at = 3'd1;
        end else if (need >= 2'd2 && !cont[2]) begin
            bad_at = 3'd2;
        end else if (need == 2'd3 && !cont[3]) begin
            bad_at = 3'd3;
        end else begin
            bad_at = 3'd0;
        end
    end

    // assembled value and range checks
    always_comb begin
        unique case (need)
            2'd1:    value = {10'd0, lead[4:0], window[1][5:0]};
            2'd2:    value = {5'd0, lead[3:0], window[1][5:0], window[2][5:0]};
            2'd3:    value = {lead[2:0], window[1][5:0], window[2][5:0], window[3][5:0]};
            default: value = '0;
        endcase
        value_ok = !(value > utf8d_pkg::CP_MAX ||
                     (value >= utf8d_pkg::SURR_LO && value <= utf8d_pkg::SURR_HI) ||
                     (need == 2'd1 && value < utf8d_pkg::MIN_TWO) ||
                     (need == 2'd2 && value < utf8d_pkg::MIN_THREE) ||
                     (need == 2'd3 && value < utf8d_pkg::MIN_FOUR));
    end

    // step outcome
    always_comb begin
        step.has_result = 1'b1;
        step.code       = utf8d_pkg::ERROR_CODE;
        step.bad        = 1'b1;
        step.drop       = 3'd1;
        if (lead < utf8d_pkg::ASCII_LIMIT) begin
            step.code = {13'd0, lead};
            step.bad  = 1'b0;
        end else if (need == 2'd0) begin
            // stray byte, keep defaults
        end else if (fill < seq_len) begin
            // short sequence: wait, or drop the lead at end of text
            step.has_result = at_end;
        end else if (bad_at != 3'd0) begin
            step.drop = bad_at;
        end else begin
            step.drop = seq_len;
            if (value_ok) begin
                step.code = value;
                step.bad  = 1'b0;
            end
        end
    end

endmodule
`default_nettype wire
